>>> hw/rtl/pvs_pkg.sv
// Shared types and constants for the palette voxel store.
package pvs_pkg;

    localparam int DEF_VOLUME        = 4096;
    localparam int DEF_PALETTE_DEPTH = 256;

    localparam logic [7:0] CFG_AIR_BLOCK = 8'd0;
    localparam logic [7:0] CFG_AIR_STATE = 8'd1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VRD,
        ST_SCAN,
        ST_SEEK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] st_code;
        logic [15:0] blk_code;
    } t_entry;

    typedef struct packed {
        logic rot;
        logic load;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/pvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pvs_cell.sv
// One palette cell of the rotating palette ring.
module pvs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pvs_pkg::t_cell_ctrl i_ctrl,
    input  pvs_pkg::t_entry     i_next,
    input  pvs_pkg::t_entry     i_load,
    output pvs_pkg::t_entry     o_entry
);
    import pvs_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.rot) begin
            n_entry = i_next;
        end else if (i_ctrl.load) begin
            n_entry = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hw/rtl/palette_voxel_store.sv
// Palette voxel store top level: control sequencer, palette cell ring, voxel RAM.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | i_s_tvalid / o_s_tready | command, voxel_index, block, state
//  m_axis   | out       | o_m_tvalid / i_m_tready | block, state, slot, count, full
//  cfg      | in        | i_cfg_valid/o_cfg_ready | register index, 16-bit data
//
// The palette is a ring of PALETTE_DEPTH cells rotated one slot per cycle; cell 0 is
// the only compare/load point. Read: voxel RAM read, then a seek of the ring to the stored slot.
// Write: a full scan of the ring, then a seek to the matching or new slot, and the store.
// Fill: seek to slot 0, then clear the voxel RAM, one word a cycle.
// After reset a clearing pass over the voxel RAM runs with o_s_tready low.
// One item at a time; the output register lets the next item in while a result waits.
module palette_voxel_store #(
    parameter int VOLUME        = pvs_pkg::DEF_VOLUME,
    parameter int PALETTE_DEPTH = pvs_pkg::DEF_PALETTE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] command, [17:2] voxel_index, [33:18] block_value, [49:34] state_value
    input  logic [55:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] out_block, [31:16] out_state, [39:32] slot_used,
    // [48:40] entries_in_use, [49] palette_full
    output logic [55:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pvs_pkg::*;

    localparam int HW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int AW = (VOLUME > 1) ? $clog2(VOLUME) : 1;
    localparam logic [16:0] VOL_L   = 17'(VOLUME);
    localparam logic [HW-1:0] HLAST = HW'(PALETTE_DEPTH - 1);
    localparam logic [CW-1:0] DEP_C = CW'(PALETTE_DEPTH);
    localparam logic [AW-1:0] ALAST = AW'(VOLUME - 1);

    t_state r_state, n_state;

    logic [15:0] r_air_block, r_air_state;
    t_cmd        r_cmd;
    logic [15:0] r_idx, r_blk, r_st;
    logic [CW-1:0] r_count, n_count;
    logic [HW-1:0] r_head, n_head;
    logic [HW-1:0] r_cnt, n_cnt;
    logic [HW-1:0] r_target, n_target;
    logic          r_found, n_found;
    logic [HW-1:0] r_fslot, n_fslot;
    logic          r_wr, n_wr;
    logic          r_full, n_full;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_is_fill, n_is_fill;

    logic [15:0]   r_res_block, n_res_block, r_res_state, n_res_state;
    logic [HW-1:0] r_res_slot, n_res_slot;
    logic          r_res_full, n_res_full;
    logic          r_out_valid, n_out_valid;
    logic [55:0]   r_out_data, n_out_data;

    t_entry     w_ent [PALETTE_DEPTH];
    t_cell_ctrl w_ctrl0;
    t_cell_ctrl w_ctrl;
    t_entry     w_key;

    logic          w_ram_we, w_ram_re;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    logic [HW-1:0] w_ram_wdata, w_ram_rdata;

    logic w_in_acc, w_in_range, w_match;
    t_cmd w_in_cmd;

    assign w_key.blk_code = r_blk;
    assign w_key.st_code  = r_st;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_block <= '0;
            r_air_state <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_AIR_BLOCK) begin
                r_air_block <= i_cfg_data;
            end else if (i_cfg_index == CFG_AIR_STATE) begin
                r_air_state <= i_cfg_data;
            end
        end
    end

    // palette ring: cell i takes cell i+1, last takes cell 0
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        pvs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  ((g == 0) ? w_ctrl0 : w_ctrl),
            .i_next  (w_ent[(g + 1) % PALETTE_DEPTH]),
            .i_load  (w_key),
            .o_entry (w_ent[g])
        );
    end

    pvs_ram #(.WIDTH(HW), .DEPTH(VOLUME), .AW(AW)) u_vox (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_in_cmd   = t_cmd'(i_s_tdata[1:0]);
    assign w_in_range = ({1'b0, i_s_tdata[17:2]} < VOL_L);
    assign w_match    = (CW'(r_head) < r_count) && (w_ent[0] == w_key);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_target    = r_target;
        n_found     = r_found;
        n_fslot     = r_fslot;
        n_wr        = r_wr;
        n_full      = r_full;
        n_clr       = r_clr;
        n_is_fill   = r_is_fill;
        n_res_block = r_res_block;
        n_res_state = r_res_state;
        n_res_slot  = r_res_slot;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_ctrl      = '0;
        w_ctrl0     = '0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr;
        w_ram_wdata = '0;
        w_ram_re    = 1'b0;
        w_ram_raddr = AW'(i_s_tdata[17:2]);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                w_ram_we = 1'b1;
                n_clr    = r_clr + AW'(1);
                if (r_clr == ALAST) begin
                    n_clr   = '0;
                    n_state = r_is_fill ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_res_block = '0;
                    n_res_state = '0;
                    n_res_slot  = '0;
                    n_res_full  = 1'b0;
                    n_wr        = 1'b0;
                    n_full      = 1'b0;
                    n_found     = 1'b0;
                    n_is_fill   = 1'b0;
                    n_cnt       = '0;
                    n_state     = ST_DONE;
                    case (w_in_cmd)
                        CMD_READ: begin
                            if (w_in_range) begin
                                w_ram_re = 1'b1;
                                n_state  = ST_VRD;
                            end else begin
                                n_res_block = r_air_block;
                                n_res_state = r_air_state;
                            end
                        end
                        CMD_WRITE: begin
                            if (w_in_range) begin
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_FILL: begin
                            n_target  = '0;
                            n_wr      = 1'b1;
                            n_is_fill = 1'b1;
                            n_count   = CW'(1);
                            n_state   = ST_SEEK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_VRD: begin
                n_res_slot = w_ram_rdata;
                if (CW'(w_ram_rdata) < r_count) begin
                    n_target = w_ram_rdata;
                    n_state  = ST_SEEK;
                end else begin
                    n_res_block = r_air_block;
                    n_res_state = r_air_state;
                    n_state     = ST_DONE;
                end
            end
            ST_SCAN: begin
                w_ctrl0 = '{rot: 1'b1, load: 1'b0};
                w_ctrl  = '{rot: 1'b1, load: 1'b0};
                n_head  = (r_head == HLAST) ? '0 : r_head + HW'(1);
                n_cnt   = r_cnt + HW'(1);
                if (w_match) begin
                    n_found = 1'b1;
                    n_fslot = r_head;
                end
                if (r_cnt == HLAST) begin
                    n_state = ST_SEEK;
                    if (r_found || w_match) begin
                        n_target = w_match ? r_head : r_fslot;
                    end else if (r_count < DEP_C) begin
                        n_target = HW'(r_count);
                        n_wr     = 1'b1;
                        n_count  = r_count + CW'(1);
                    end else begin
                        n_target = '0;
                        n_full   = 1'b1;
                    end
                end
            end
            ST_SEEK: begin
                if (r_head == r_target) begin
                    n_res_slot = r_target;
                    n_res_full = r_full;
                    if (r_wr) begin
                        w_ctrl0     = '{rot: 1'b0, load: 1'b1};
                        n_res_block = r_blk;
                        n_res_state = r_st;
                    end else begin
                        n_res_block = w_ent[0].blk_code;
                        n_res_state = w_ent[0].st_code;
                    end
                    if (r_cmd == CMD_WRITE) begin
                        w_ram_we    = 1'b1;
                        w_ram_waddr = AW'(r_idx);
                        w_ram_wdata = r_target;
                    end
                    n_state = r_is_fill ? ST_CLEAR : ST_DONE;
                end else begin
                    w_ctrl0 = '{rot: 1'b1, load: 1'b0};
                    w_ctrl  = '{rot: 1'b1, load: 1'b0};
                    n_head  = (r_head == HLAST) ? '0 : r_head + HW'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_res_full, 9'(r_count), 8'(r_res_slot),
                                   r_res_state, r_res_block};
                    n_is_fill   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_count     <= CW'(1);
            r_head      <= '0;
            r_cnt       <= '0;
            r_target    <= '0;
            r_found     <= 1'b0;
            r_fslot     <= '0;
            r_wr        <= 1'b0;
            r_full      <= 1'b0;
            r_clr       <= '0;
            r_is_fill   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_target    <= n_target;
            r_found     <= n_found;
            r_fslot     <= n_fslot;
            r_wr        <= n_wr;
            r_full      <= n_full;
            r_clr       <= n_clr;
            r_is_fill   <= n_is_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= w_in_cmd;
            r_idx <= i_s_tdata[17:2];
            r_blk <= i_s_tdata[33:18];
            r_st  <= i_s_tdata[49:34];
        end
        r_res_block <= n_res_block;
        r_res_state <= n_res_state;
        r_res_slot  <= n_res_slot;
        r_res_full  <= n_res_full;
        r_out_data  <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> bench/palette_voxel_store_test.sv
// Self-checking stimulus and result checking for the palette voxel store.
module palette_voxel_store_test;
    import pvs_pkg::*;

    localparam int VOL   = DEF_VOLUME;
    localparam int DEPTH = DEF_PALETTE_DEPTH;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;
    localparam logic [7:0] CFG_UNUSED = 8'd7;

    typedef struct packed {
        logic        full;
        logic [8:0]  count;
        logic [7:0]  slot;
        logic [15:0] st;
        logic [15:0] blk;
    } t_result;

    typedef struct {
        t_cmd        cmd;
        logic [15:0] idx;
        logic [15:0] blk;
        logic [15:0] st;
        bit          typed;
        t_result     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [55:0] i_s_tdata = '0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_s_tready, o_m_tvalid, o_cfg_ready;
    logic [55:0] o_m_tdata;

    palette_voxel_store dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] air_blk, air_st;
    logic [15:0] pal_blk [DEPTH];
    logic [15:0] pal_st  [DEPTH];
    int          pal_count;
    logic [7:0]  slots [VOL];

    t_result expected_results [$];
    int      errors = 0;
    longint  cycles = 0;
    bit      calm = 1'b0;

    function automatic t_result predict_store(t_cmd cmd, logic [15:0] idx,
                                              logic [15:0] blk, logic [15:0] st);
        t_result r;
        int      s;
        r = '0;
        case (cmd)
            CMD_READ: begin
                r.blk = air_blk;
                r.st  = air_st;
                if (idx < VOL) begin
                    s = int'(slots[idx]);
                    r.slot = 8'(s);
                    if (s < pal_count) begin
                        r.blk = pal_blk[s];
                        r.st  = pal_st[s];
                    end
                end
            end
            CMD_WRITE: begin
                if (idx < VOL) begin
                    s = -1;
                    for (int i = 0; i < pal_count; i++)
                        if (s < 0 && pal_blk[i] == blk && pal_st[i] == st) s = i;
                    if (s < 0) begin
                        if (pal_count >= DEPTH) begin
                            s = 0;
                            r.full = 1'b1;
                        end else begin
                            s = pal_count;
                            pal_blk[s] = blk;
                            pal_st[s]  = st;
                            pal_count++;
                        end
                    end
                    slots[idx] = 8'(s);
                    r.slot = 8'(s);
                    r.blk  = pal_blk[s];
                    r.st   = pal_st[s];
                end
            end
            CMD_FILL: begin
                pal_blk[0] = blk;
                pal_st[0]  = st;
                pal_count  = 1;
                foreach (slots[i]) slots[i] = '0;
                r.blk = blk;
                r.st  = st;
            end
            default: ;
        endcase
        r.count = 9'(pal_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // cycle counter, receiver stall and result check
    always @(posedge i_clk) begin
        t_result got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[49:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", got[31:0], 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.blk != want.blk)
                    report_mismatch("out_block", 32'(got.blk), 32'(want.blk));
                if (got.st != want.st)
                    report_mismatch("out_state", 32'(got.st), 32'(want.st));
                if (got.slot != want.slot)
                    report_mismatch("slot_used", 32'(got.slot), 32'(want.slot));
                if (got.count != want.count)
                    report_mismatch("entries_in_use", 32'(got.count), 32'(want.count));
                if (got.full != want.full)
                    report_mismatch("palette_full", 32'(got.full), 32'(want.full));
            end
        end
        i_m_tready <= calm || ($urandom_range(99) >= 21);
    end

    task automatic send_item(t_cmd cmd, logic [15:0] idx, logic [15:0] blk,
                             logic [15:0] st, bit typed, t_result res);
        t_result p;
        while (!calm && $urandom_range(99) < 21) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, st, blk, idx, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        p = predict_store(cmd, idx, blk, st);
        if (typed && p != res) report_mismatch("directed row", p[31:0], res[31:0]);
        expected_results.insert(expected_results.size(), p);
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2 * VOL + 3 * DEPTH) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_AIR_BLOCK) air_blk = val;
        else if (idx == CFG_AIR_STATE) air_st = val;
        @(posedge i_clk);
    endtask

    function automatic t_result mk(logic [15:0] b, logic [15:0] s, logic [7:0] sl,
                                   logic [8:0] c, logic f);
        return '{full: f, count: c, slot: sl, st: s, blk: b};
    endfunction

    function automatic logic [15:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'($urandom_range(65535, VOL));
        if (r < 70) return 16'($urandom_range(31));
        return 16'($urandom_range(VOL - 1));
    endfunction

    initial begin
        t_row rows [$];
        t_cmd cmd;
        logic [15:0] b, s;
        int r;
        air_blk = 0;
        air_st = 0;
        pal_count = 1;
        foreach (pal_blk[i]) begin
            pal_blk[i] = 0;
            pal_st[i] = 0;
        end
        foreach (slots[i]) slots[i] = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.insert(rows.size(), '{CMD_READ, 16'd0, 16'hffff, 16'hffff, 1,
                                   mk(0, 0, 0, 1, 0)});
        rows.insert(rows.size(), '{CMD_READ, 16'hffff, 16'd0, 16'd0, 1,
                                   mk(0, 0, 0, 1, 0)});
        rows.insert(rows.size(), '{CMD_WRITE, 16'hffff, 16'h1234, 16'h5, 1,
                                   mk(0, 0, 0, 1, 0)});
        rows.insert(rows.size(), '{CMD_NOP, 16'h3, 16'hffff, 16'hffff, 1,
                                   mk(0, 0, 0, 1, 0)});
        rows.insert(rows.size(), '{CMD_WRITE, 16'd0, 16'hffff, 16'hffff, 1,
                                   mk(16'hffff, 16'hffff, 1, 2, 0)});
        rows.insert(rows.size(), '{CMD_WRITE, 16'(VOL - 1), 16'hffff, 16'hffff, 1,
                                   mk(16'hffff, 16'hffff, 1, 2, 0)});
        rows.insert(rows.size(), '{CMD_WRITE, 16'd1, 16'd0, 16'd0, 0, '0});
        rows.insert(rows.size(), '{CMD_READ, 16'(VOL - 1), 16'd0, 16'd0, 0, '0});
        rows.insert(rows.size(), '{CMD_READ, 16'(VOL), 16'd0, 16'd0, 1,
                                   mk(0, 0, 0, 2, 0)});
        rows.insert(rows.size(), '{CMD_FILL, 16'h77, 16'haaaa, 16'h5555, 1,
                                   mk(16'haaaa, 16'h5555, 0, 1, 0)});
        // voxel 0 now holds slot 0; read it back after refilling
        rows.insert(rows.size(), '{CMD_READ, 16'd0, 16'd0, 16'd0, 1,
                                   mk(16'haaaa, 16'h5555, 0, 1, 0)});
        rows.insert(rows.size(), '{CMD_WRITE, 16'd5, 16'h1, 16'h2, 0, '0});
        rows.insert(rows.size(), '{CMD_WRITE, 16'd6, 16'h3, 16'h4, 0, '0});
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].idx, rows[i].blk, rows[i].st,
                      rows[i].typed, rows[i].res);
        drain();

        // slot beyond count cannot be kept this way, since a fill clears the voxel RAM;
        // so instead grow the palette to full and read an out-of-range voxel for air and count.
        write_reg(CFG_AIR_BLOCK, 16'hffff);
        write_reg(CFG_AIR_STATE, 16'hffff);
        write_reg(CFG_UNUSED, 16'h1234);
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(CMD_WRITE, 16'(i), 16'(i + 100), 16'(i), 0, '0);
        send_item(CMD_READ, 16'hffff, 16'd0, 16'd0, 1,
                  mk(16'hffff, 16'hffff, 0, 9'(DEPTH), 0));
        send_item(CMD_WRITE, 16'd9, 16'hbeef, 16'hbeef, 0, '0);
        drain();

        // random phases with different air settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_AIR_BLOCK, ph == 0 ? 16'h0 : 16'($urandom));
            write_reg(CFG_AIR_STATE, ph == 1 ? 16'hffff : 16'($urandom));
            calm = (ph == 2);
            for (int n = 0; n < 440; n++) begin
                r = $urandom_range(999);
                if (r < 4) cmd = CMD_FILL;
                else if (r < 10) cmd = CMD_NOP;
                else if (r < 500) cmd = CMD_WRITE;
                else cmd = CMD_READ;
                b = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
                s = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
                send_item(cmd, pick_index(), b, s, 0, '0);
            end
            calm = 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
